FILE: rtl/csd_pkg.sv
// package for the clap sequence detector: item and result types, config
// register codes and reset values, detection kinds. no dependencies.
`timescale 1ns / 1ps

package csd_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned KIND_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  localparam logic [CFG_W-1:0] RESTART_GAP_RST = 16'd2000;
  localparam logic [CFG_W-1:0] EARLY_LOW_RST   = 16'd100;
  localparam logic [CFG_W-1:0] EARLY_HIGH_RST  = 16'd800;
  localparam logic [CFG_W-1:0] LATE_LOW_RST    = 16'd150;
  localparam logic [CFG_W-1:0] LATE_HIGH_RST   = 16'd400;
  localparam logic [CFG_W-1:0] QUIET_TIME_RST  = 16'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESTART_GAP = 3'd0,
    CFG_EARLY_LOW   = 3'd1,
    CFG_EARLY_HIGH  = 3'd2,
    CFG_LATE_LOW    = 3'd3,
    CFG_LATE_HIGH   = 3'd4,
    CFG_QUIET_TIME  = 3'd5
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_TRIPLE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              clap_heard;
    logic              clear_order;
  } clap_item_t;

  typedef struct packed {
    logic              order_ready;
    logic [KIND_W-1:0] order_kind;
    logic [COUNT_W-1:0] claps_counted;
  } order_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] restart_gap_ms;
    logic [CFG_W-1:0] early_window_low_ms;
    logic [CFG_W-1:0] early_window_high_ms;
    logic [CFG_W-1:0] late_window_low_ms;
    logic [CFG_W-1:0] late_window_high_ms;
    logic [CFG_W-1:0] quiet_time_ms;
  } cfg_t;

endpackage

FILE: rtl/csd_chan_if.sv
// valid/ready channel carrying one item of a given payload type
// used by the clap sequence detector ports
`timescale 1ns / 1ps

interface csd_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/csd_cfg_regs.sv
// timing window and quiet time registers of the clap sequence detector
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [csd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csd_pkg::CFG_W-1:0]      cfg_data,
  output csd_pkg::cfg_t                  cfg
);
  import csd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.restart_gap_ms       <= RESTART_GAP_RST;
      cfg.early_window_low_ms  <= EARLY_LOW_RST;
      cfg.early_window_high_ms <= EARLY_HIGH_RST;
      cfg.late_window_low_ms   <= LATE_LOW_RST;
      cfg.late_window_high_ms  <= LATE_HIGH_RST;
      cfg.quiet_time_ms        <= QUIET_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_RESTART_GAP: cfg.restart_gap_ms       <= cfg_data;
        CFG_EARLY_LOW:   cfg.early_window_low_ms  <= cfg_data;
        CFG_EARLY_HIGH:  cfg.early_window_high_ms <= cfg_data;
        CFG_LATE_LOW:    cfg.late_window_low_ms   <= cfg_data;
        CFG_LATE_HIGH:   cfg.late_window_high_ms  <= cfg_data;
        CFG_QUIET_TIME:  cfg.quiet_time_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/csd_seq_core.sv
// sequence state (last clap time, clap count, sticky kind) and the
// combinational step logic that updates it; depends on csd_pkg
`timescale 1ns / 1ps

module csd_seq_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  csd_pkg::clap_item_t  item,
  input  csd_pkg::cfg_t        cfg,
  output csd_pkg::order_item_t result
);
  import csd_pkg::*;

  logic [TIME_W-1:0]  last_clap_time;
  logic [TIME_W-1:0]  last_clap_time_next;
  logic [COUNT_W-1:0] clap_count;
  logic [COUNT_W-1:0] clap_count_next;
  kind_e              detected_kind;
  kind_e              detected_kind_next;
  logic               ready_next;

  logic [TIME_W-1:0]  gap;
  logic               long_gap;
  logic               quiet;
  logic               in_early;
  logic               in_late;

  assign gap      = item.now_ms - last_clap_time;
  assign long_gap = gap > {16'd0, cfg.restart_gap_ms};
  assign quiet    = gap > {16'd0, cfg.quiet_time_ms};
  assign in_early = (gap > {16'd0, cfg.early_window_low_ms}) &&
                    (gap < {16'd0, cfg.early_window_high_ms});
  assign in_late  = (gap > {16'd0, cfg.late_window_low_ms}) &&
                    (gap < {16'd0, cfg.late_window_high_ms});

  always_comb begin
    last_clap_time_next = last_clap_time;
    clap_count_next     = clap_count;
    detected_kind_next  = item.clear_order ? KIND_NONE : detected_kind;
    ready_next          = 1'b0;
    if (item.clap_heard) begin
      last_clap_time_next = item.now_ms;
      if (long_gap) begin
        clap_count_next = 8'd1;
      end else if (clap_count == 8'd1 || clap_count == 8'd2) begin
        if (in_early) begin
          clap_count_next = clap_count + 8'd1;
        end
      end else if (clap_count > 8'd2) begin
        if (in_late && clap_count != COUNT_MAX) begin
          clap_count_next = clap_count + 8'd1;
        end
      end
    end else if (quiet) begin
      if (clap_count == 8'd2) begin
        clap_count_next    = '0;
        detected_kind_next = KIND_DOUBLE;
        ready_next         = 1'b1;
      end else if (clap_count == 8'd3) begin
        clap_count_next    = '0;
        detected_kind_next = KIND_TRIPLE;
        ready_next         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_clap_time <= '0;
      clap_count     <= '0;
      detected_kind  <= KIND_NONE;
    end else if (fire) begin
      last_clap_time <= last_clap_time_next;
      clap_count     <= clap_count_next;
      detected_kind  <= detected_kind_next;
    end
  end

  assign result.order_ready   = ready_next;
  assign result.order_kind    = detected_kind_next;
  assign result.claps_counted = clap_count_next;

endmodule

FILE: rtl/clap_sequence_detector_unit.sv
// top level of the clap sequence detector: input register, step core,
// result register; depends on csd_pkg, csd_chan_if, csd_cfg_regs, csd_seq_core
`timescale 1ns / 1ps

// Takes one item per clock when the result side does not stall and returns
// one result item for each, in order. An accepted item waits in the input
// register until the step logic (a 32-bit gap subtraction and six 32-bit
// compares against zero-extended 16-bit config values) updates the sequence
// state and loads the result register, which offers the result. The state
// loop closes in that one step, which allows a new item every cycle when the
// result side does not stall. Back-pressure on the result side holds the
// result register and then the input register; input ready depends
// combinationally on result ready. Configuration registers reset to the
// default windows and must be written only while no item is in flight.

module clap_sequence_detector_unit (
  input  logic                          clk,
  input  logic                          rst,
  csd_chan_if.sink                      clap_ch,
  csd_chan_if.source                    order_ch,
  input  logic                          cfg_we,
  input  logic [csd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csd_pkg::CFG_W-1:0]     cfg_data
);
  import csd_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  clap_item_t  in_item;
  logic        out_valid;
  order_item_t out_item;
  order_item_t step_result;
  logic        fire;
  logic        accept;

  csd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csd_seq_core u_seq_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (step_result)
  );

  assign fire          = in_valid && (!out_valid || order_ch.ready);
  assign clap_ch.ready = !in_valid || fire;
  assign accept        = clap_ch.valid && clap_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= clap_ch.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (order_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= step_result;
    end
  end

  assign order_ch.valid   = out_valid;
  assign order_ch.payload = out_item;

endmodule

FILE: rtl/csd_checker.sv
// port-level checks for the clap sequence detector, bound to the top level
// depends on csd_pkg and clap_sequence_detector_unit
`timescale 1ns / 1ps

module csd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        clap_valid,
  input logic                        clap_ready,
  input logic                        order_valid,
  input logic                        order_ready_hs,
  input logic                        order_ready,
  input logic [csd_pkg::KIND_W-1:0]  order_kind,
  input logic [csd_pkg::COUNT_W-1:0] claps_counted
);
  import csd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (order_valid && !order_ready_hs) |=>
      (order_valid && $stable(order_ready) && $stable(order_kind) &&
       $stable(claps_counted)))
    else $error("result changed while stalled");

  // every accepted item must be followed by a valid result on the order channel
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (clap_valid && clap_ready) |-> ##2 order_valid)
    else $error("no result after accepted item");

  // a completed sequence clears the count and sets a kind
  a_report: assert property (@(posedge clk) disable iff (rst)
    (order_valid && order_ready) |->
      (claps_counted == '0 &&
       (order_kind == KIND_DOUBLE || order_kind == KIND_TRIPLE)))
    else $error("report without cleared count and kind");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !order_valid)
    else $error("result valid after reset");

endmodule

bind clap_sequence_detector_unit csd_checker u_csd_checker (
  .clk            (clk),
  .rst            (rst),
  .clap_valid     (clap_ch.valid),
  .clap_ready     (clap_ch.ready),
  .order_valid    (order_ch.valid),
  .order_ready_hs (order_ch.ready),
  .order_ready    (order_ch.payload.order_ready),
  .order_kind     (order_ch.payload.order_kind),
  .claps_counted  (order_ch.payload.claps_counted)
);

FILE: test/tb_clap_sequence_detector_unit.sv
// testbench for clap_sequence_detector_unit: drives clap items with bursts and gaps,
// predicts each order item and checks it field by field under several window settings
// depends on csd_pkg, csd_chan_if and the detector rtl
`timescale 1ns / 1ps

module tb_clap_sequence_detector_unit;
  import csd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_QUIET_TIME + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  csd_chan_if #(.payload_t(clap_item_t))  clap_ch ();
  csd_chan_if #(.payload_t(order_item_t)) order_ch ();

  clap_sequence_detector_unit uut (
    .clk       (clk),
    .rst       (rst),
    .clap_ch   (clap_ch),
    .order_ch  (order_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // detector state as predicted
  cfg_t             cfg_shadow;
  logic [TIME_W-1:0] last_clap_ms;
  logic [COUNT_W-1:0] clap_tally;
  kind_e            sticky_kind;

  clap_item_t  claps_pending[$];
  order_item_t orders_due[$];
  logic [TIME_W-1:0] gen_last_clap;
  int items_queued;
  int mismatch_count;

  int burst_left;
  int gap_left;
  int rx_cycle;
  int rx_mode;
  order_item_t want;
  order_item_t got;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic order_item_t predict_order(input clap_item_t it);
    logic [TIME_W-1:0] gap;
    order_item_t res;
    gap = it.now_ms - last_clap_ms;
    res.order_ready = 1'b0;
    if (it.clear_order) sticky_kind = KIND_NONE;
    if (it.clap_heard) begin
      if (gap > cfg_shadow.restart_gap_ms) begin
        clap_tally = 8'd1;
      end else if (clap_tally == 8'd1 || clap_tally == 8'd2) begin
        if (gap > cfg_shadow.early_window_low_ms && gap < cfg_shadow.early_window_high_ms)
          clap_tally = clap_tally + 8'd1;
      end else if (clap_tally > 8'd2) begin
        if (gap > cfg_shadow.late_window_low_ms && gap < cfg_shadow.late_window_high_ms &&
            clap_tally != COUNT_MAX)
          clap_tally = clap_tally + 8'd1;
      end
      last_clap_ms = it.now_ms;
    end else if (gap > cfg_shadow.quiet_time_ms) begin
      if (clap_tally == 8'd2) begin
        clap_tally = '0;
        sticky_kind = KIND_DOUBLE;
        res.order_ready = 1'b1;
      end else if (clap_tally == 8'd3) begin
        clap_tally = '0;
        sticky_kind = KIND_TRIPLE;
        res.order_ready = 1'b1;
      end
    end
    res.order_kind = sticky_kind;
    res.claps_counted = clap_tally;
    return res;
  endfunction

  // driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      clap_ch.valid <= 1'b0;
      clap_ch.payload <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (clap_ch.valid && clap_ch.ready)
        orders_due.push_back(predict_order(clap_ch.payload));
      if (!clap_ch.valid || clap_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          clap_ch.valid <= 1'b0;
        end else if (claps_pending.size() > 0) begin
          clap_ch.valid <= 1'b1;
          clap_ch.payload <= claps_pending.pop_front();
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(0, 5);
        end else begin
          clap_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each order item, stalls on a randomly chosen ready pattern
  always @(posedge clk) begin
    if (rst) begin
      order_ch.ready <= 1'b0;
      rx_cycle = 0;
      rx_mode = 0;
    end else begin
      if (order_ch.valid && order_ch.ready) begin
        got = order_ch.payload;
        if (orders_due.size() == 0) begin
          $error("order item with none expected: ready %0d kind %0d count %0d",
                 got.order_ready, got.order_kind, got.claps_counted);
          mismatch_count++;
        end else begin
          want = orders_due.pop_front();
          if (got.order_ready !== want.order_ready) begin
            $error("order_ready: expected %0d, got %0d", want.order_ready, got.order_ready);
            mismatch_count++;
          end
          if (got.order_kind !== want.order_kind) begin
            $error("order_kind: expected %0d, got %0d", want.order_kind, got.order_kind);
            mismatch_count++;
          end
          if (got.claps_counted !== want.claps_counted) begin
            $error("claps_counted: expected %0d, got %0d",
                   want.claps_counted, got.claps_counted);
            mismatch_count++;
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: order_ch.ready <= 1'b1;
        1: order_ch.ready <= ($urandom_range(0, 3) != 0);
        2: order_ch.ready <= (rx_cycle % 3 != 0);
        default: order_ch.ready <= (rx_cycle % 9 < 2);
      endcase
    end
  end

  task automatic queue_clap(input logic [TIME_W-1:0] t, input logic clap, input logic clr);
    clap_item_t it;
    it.now_ms = t;
    it.clap_heard = clap;
    it.clear_order = clr;
    claps_pending.push_back(it);
    items_queued++;
    if (clap) gen_last_clap = t;
  endtask

  function automatic logic coin_clear();
    return $urandom_range(0, 7) == 0;
  endfunction

  // a sequence opening after a long gap, intervals inside the windows unless missed (miss_pct percent)
  task automatic queue_sequence(input int n_claps, input int miss_pct);
    logic [TIME_W-1:0] t;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    int k;
    queue_clap(gen_last_clap + 32'(cfg_shadow.restart_gap_ms) + 32'd1 +
               32'($urandom_range(0, 3000)), 1'b1, coin_clear());
    for (k = 2; k <= n_claps; k++) begin
      lo = (k <= 3) ? cfg_shadow.early_window_low_ms : cfg_shadow.late_window_low_ms;
      hi = (k <= 3) ? cfg_shadow.early_window_high_ms : cfg_shadow.late_window_high_ms;
      if (int'(hi) > int'(lo) + 1 && $urandom_range(0, 99) >= miss_pct)
        t = gen_last_clap + 32'($urandom_range(int'(lo) + 1, int'(hi) - 1));
      else
        t = gen_last_clap + 32'($urandom_range(0, int'(hi) + 200));
      queue_clap(t, 1'b1, coin_clear());
    end
    repeat ($urandom_range(0, 2))
      queue_clap(gen_last_clap + 32'($urandom_range(0, int'(cfg_shadow.quiet_time_ms))),
                 1'b0, coin_clear());
    queue_clap(gen_last_clap + 32'(cfg_shadow.quiet_time_ms) + 32'($urandom_range(0, 400)),
               1'b0, coin_clear());
  endtask

  task automatic queue_random_phase(input int n_items);
    int stop_at;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: queue_sequence($urandom_range(1, 6), 10);
        6: queue_sequence($urandom_range(2, 12), 60);
        7, 8: queue_clap($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: queue_clap(gen_last_clap + 32'($urandom_range(0, 200)), 1'b0, 1'b1);
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_RESTART_GAP: cfg_shadow.restart_gap_ms = val;
      CFG_EARLY_LOW:   cfg_shadow.early_window_low_ms = val;
      CFG_EARLY_HIGH:  cfg_shadow.early_window_high_ms = val;
      CFG_LATE_LOW:    cfg_shadow.late_window_low_ms = val;
      CFG_LATE_HIGH:   cfg_shadow.late_window_high_ms = val;
      CFG_QUIET_TIME:  cfg_shadow.quiet_time_ms = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input cfg_t c);
    logic [CFG_IDX_W-1:0] spare;
    write_reg(CFG_RESTART_GAP, c.restart_gap_ms);
    write_reg(CFG_EARLY_LOW, c.early_window_low_ms);
    write_reg(CFG_EARLY_HIGH, c.early_window_high_ms);
    write_reg(CFG_LATE_LOW, c.late_window_low_ms);
    write_reg(CFG_LATE_HIGH, c.late_window_high_ms);
    write_reg(CFG_QUIET_TIME, c.quiet_time_ms);
    spare = CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
    write_reg(spare, 16'($urandom()));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (claps_pending.size() != 0 || clap_ch.valid || orders_due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    int ph;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_RESTART_GAP;
    cfg_data = '0;
    clap_ch.valid = 1'b0;
    clap_ch.payload = '0;
    order_ch.ready = 1'b0;
    cfg_shadow.restart_gap_ms = RESTART_GAP_RST;
    cfg_shadow.early_window_low_ms = EARLY_LOW_RST;
    cfg_shadow.early_window_high_ms = EARLY_HIGH_RST;
    cfg_shadow.late_window_low_ms = LATE_LOW_RST;
    cfg_shadow.late_window_high_ms = LATE_HIGH_RST;
    cfg_shadow.quiet_time_ms = QUIET_TIME_RST;
    last_clap_ms = '0;
    clap_tally = '0;
    sticky_kind = KIND_NONE;
    gen_last_clap = '0;
    items_queued = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed items on the reset windows
    queue_clap(32'd500, 1'b1, 1'b0);    // clap at zero count within restart gap
    queue_clap(32'd3000, 1'b1, 1'b0);
    queue_clap(32'd3100, 1'b1, 1'b0);   // on the early low bound
    queue_clap(32'd3900, 1'b1, 1'b0);   // on the early high bound
    queue_clap(32'd4300, 1'b1, 1'b0);
    queue_clap(32'd5800, 1'b0, 1'b0);   // silence equal to quiet time
    queue_clap(32'd5801, 1'b0, 1'b1);   // clear and double on one item
    queue_clap(32'd5802, 1'b0, 1'b0);
    queue_clap(32'd8000, 1'b1, 1'b0);
    queue_clap(32'd8300, 1'b1, 1'b0);
    queue_clap(32'd8600, 1'b1, 1'b0);
    queue_clap(32'd8800, 1'b1, 1'b0);
    queue_clap(32'd9000, 1'b1, 1'b0);
    queue_clap(32'd12000, 1'b0, 1'b0);  // count above three, no report
    queue_clap(32'd12001, 1'b0, 1'b1);
    queue_clap(32'd20000, 1'b1, 1'b0);
    queue_clap(32'd20500, 1'b1, 1'b0);
    queue_clap(32'd21000, 1'b1, 1'b0);
    queue_clap(32'd22600, 1'b0, 1'b0);  // triple
    queue_clap(32'hFFFF_FF00, 1'b1, 1'b0);
    queue_clap(32'h0000_00C8, 1'b1, 1'b0); // interval across the wrap
    queue_clap(32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_clap(32'h0000_0000, 1'b0, 1'b1);
    wait_drained();

    // wide windows: run the count into saturation
    c.restart_gap_ms = '1;
    c.early_window_low_ms = '0;
    c.early_window_high_ms = '1;
    c.late_window_low_ms = '0;
    c.late_window_high_ms = '1;
    c.quiet_time_ms = '1;
    load_config(c);
    queue_clap(gen_last_clap + 32'd70000, 1'b1, 1'b0);
    repeat (259) queue_clap(gen_last_clap + 32'd10, 1'b1, 1'b0);
    queue_clap(gen_last_clap + 32'd70000, 1'b0, 1'b0);
    queue_clap(gen_last_clap + 32'd100, 1'b1, 1'b1);
    queue_clap(gen_last_clap + 32'd70000, 1'b1, 1'b0);
    wait_drained();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: c = '0;
        1: c = '1;
        2: begin
          // reversed windows
          c.restart_gap_ms = 16'($urandom_range(500, 5000));
          c.early_window_low_ms = 16'($urandom_range(400, 900));
          c.early_window_high_ms = 16'($urandom_range(0, 399));
          c.late_window_low_ms = 16'($urandom_range(300, 600));
          c.late_window_high_ms = 16'($urandom_range(0, 299));
          c.quiet_time_ms = 16'($urandom_range(200, 3000));
        end
        3: c = {$urandom(), $urandom(), $urandom()};
        default: begin
          c.restart_gap_ms = 16'($urandom_range(300, 5000));
          c.early_window_low_ms = 16'($urandom_range(0, 300));
          c.early_window_high_ms = c.early_window_low_ms + 16'($urandom_range(0, 900));
          c.late_window_low_ms = 16'($urandom_range(0, 300));
          c.late_window_high_ms = c.late_window_low_ms + 16'($urandom_range(0, 600));
          c.quiet_time_ms = 16'($urandom_range(200, 3000));
        end
      endcase
      load_config(c);
      queue_random_phase(26);
      wait_drained();
    end

    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/csd_pkg.sv
rtl/csd_chan_if.sv
rtl/csd_cfg_regs.sv
rtl/csd_seq_core.sv
rtl/clap_sequence_detector_unit.sv
rtl/csd_checker.sv
test/tb_clap_sequence_detector_unit.sv
